// File: src/rti_pkg.sv
// shared types, widths and codes of the ray/triangle intersection pipeline
// no dependencies; every other file takes names from here by scope
package rti_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  // exact integer widths along the datapath
  localparam int EdgeW  = CoordW + 1;
  localparam int ProdW  = 2 * EdgeW;
  localparam int CrossW = ProdW + 1;
  localparam int LoW    = CoordW;
  localparam int HiW    = CrossW - LoW;
  localparam int HiPW   = HiW + EdgeW;
  localparam int LoPW   = LoW + 1 + EdgeW;
  localparam int TermW  = CrossW + EdgeW;
  localparam int SumW   = TermW + 2;
  localparam int ChunkW = (SumW + 2) / 3;
  localparam int PartW  = CoordW + ChunkW + 1;
  localparam int MagW   = CoordW + 3 * ChunkW;
  localparam int QuoW   = CoordW + 1;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_MISS  = 2'd0,
    STAT_HIT   = 2'd1,
    STAT_PLANE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t dx, dy, dz;
  } ray_t;

  typedef struct packed {
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } tri_t;

  typedef struct packed {
    status_t          status;
    logic [SumW-1:0]  den;
    logic [SumW-1:0]  num;
  } geom_res_t;

  typedef struct packed {
    status_t               status;
    logic [SumW-1:0]       den;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    logic [2:0][SumW-1:0]  rem;
    logic [2:0][QuoW-1:0]  mlo;
  } scale_res_t;

  typedef struct packed {
    status_t status;
    coord_t  x, y, z;
  } hit_res_t;

endpackage

// File: src/rti_geom.sv
// geometry stages: edges, cross products, dot products and the hit decision
// depends on rti_pkg
module rti_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  rti_pkg::ray_t      ray,
  input  logic               in_valid,
  output logic               in_stall,
  input  rti_pkg::tri_t      in_tri,
  output logic               out_valid,
  input  logic               out_stall,
  output rti_pkg::geom_res_t out_res
);

  localparam int NStg = 8;
  localparam int CW   = rti_pkg::CoordW;
  localparam int EW   = rti_pkg::EdgeW;
  localparam int PW   = rti_pkg::ProdW;
  localparam int NW   = rti_pkg::CrossW;
  localparam int LW   = rti_pkg::LoW;
  localparam int HPW  = rti_pkg::HiPW;
  localparam int LPW  = rti_pkg::LoPW;
  localparam int TW   = rti_pkg::TermW;
  localparam int SW   = rti_pkg::SumW;
  localparam int XW   = SW + 2;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] go;

  logic signed [CW-1:0] a [3];
  logic signed [CW-1:0] b [3];
  logic signed [CW-1:0] c [3];
  logic signed [CW-1:0] o [3];
  logic signed [CW-1:0] d [3];

  logic signed [EW-1:0]  ue_r [3];
  logic signed [EW-1:0]  ve_r [3];
  logic signed [EW-1:0]  we_r [3];
  logic signed [EW-1:0]  w2_r [3];
  logic signed [EW-1:0]  w3_r [3];
  logic signed [PW-1:0]  na_r [3];
  logic signed [PW-1:0]  nb_r [3];
  logic signed [PW-1:0]  ma_r [3];
  logic signed [PW-1:0]  mb_r [3];
  logic signed [PW-1:0]  pa_r [3];
  logic signed [PW-1:0]  pb_r [3];
  logic signed [NW-1:0]  n_r [3];
  logic signed [NW-1:0]  m_r [3];
  logic signed [NW-1:0]  p_r [3];
  logic signed [NW-1:0]  xv [4][3];
  logic signed [EW-1:0]  yv [4][3];
  logic signed [HPW-1:0] hp_r [4][3];
  logic signed [LPW-1:0] lp_r [4][3];
  logic signed [TW-1:0]  tm_r [4][3];
  logic signed [SW-1:0]  sm_r [4];
  logic                  nz4_r, nz5_r, nz6_r, nz7_r;
  logic signed [SW-1:0]  den7_r, num7_r, sn7_r, tn7_r;
  logic                  dz7_r, numz7_r;
  logic signed [XW-1:0]  rest;
  rti_pkg::status_t      st;
  rti_pkg::geom_res_t    res_r;

  assign a[0] = in_tri.ax;
  assign a[1] = in_tri.ay;
  assign a[2] = in_tri.az;
  assign b[0] = in_tri.bx;
  assign b[1] = in_tri.by;
  assign b[2] = in_tri.bz;
  assign c[0] = in_tri.cx;
  assign c[1] = in_tri.cy;
  assign c[2] = in_tri.cz;
  assign o[0] = ray.ox;
  assign o[1] = ray.oy;
  assign o[2] = ray.oz;
  assign d[0] = ray.dx;
  assign d[1] = ray.dy;
  assign d[2] = ray.dz;

  // a stage loads when it is empty or its successor moves
  assign go[NStg-1] = !vld_r[NStg-1] || !out_stall;
  for (genvar i = 0; i < NStg - 1; i++) begin : g_go
    assign go[i] = !vld_r[i] || go[i+1];
  end

  assign in_stall  = !go[0];
  assign out_valid = vld_r[NStg-1];
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // operands of the four dot products: n.d, n.w0, (w0 x v).d, (u x w0).d
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xv[0][k] = n_r[k];
      yv[0][k] = EW'(d[k]);
      xv[1][k] = n_r[k];
      yv[1][k] = w3_r[k];
      xv[2][k] = m_r[k];
      yv[2][k] = EW'(d[k]);
      xv[3][k] = p_r[k];
      yv[3][k] = EW'(d[k]);
    end
  end

  always_comb begin
    rest = XW'(den7_r) - XW'(sn7_r) - XW'(tn7_r);
    if (nz7_r) begin
      st = rti_pkg::STAT_MISS;
    end else if (dz7_r) begin
      st = numz7_r ? rti_pkg::STAT_PLANE : rti_pkg::STAT_MISS;
    end else if (num7_r[SW-1] || sn7_r[SW-1] || tn7_r[SW-1] || rest[XW-1]) begin
      st = rti_pkg::STAT_MISS;
    end else begin
      st = rti_pkg::STAT_HIT;
    end
  end

  always_ff @(posedge clk) begin
    // edges and origin offset
    if (go[0]) begin
      for (int k = 0; k < 3; k++) begin
        ue_r[k] <= EW'(b[k]) - EW'(a[k]);
        ve_r[k] <= EW'(c[k]) - EW'(a[k]);
        we_r[k] <= EW'(o[k]) - EW'(a[k]);
      end
    end
    // cross product terms
    if (go[1]) begin
      for (int k = 0; k < 3; k++) begin
        na_r[k] <= PW'(ue_r[(k == 2) ? 0 : k + 1]) * PW'(ve_r[(k == 0) ? 2 : k - 1]);
        nb_r[k] <= PW'(ue_r[(k == 0) ? 2 : k - 1]) * PW'(ve_r[(k == 2) ? 0 : k + 1]);
        ma_r[k] <= PW'(we_r[(k == 2) ? 0 : k + 1]) * PW'(ve_r[(k == 0) ? 2 : k - 1]);
        mb_r[k] <= PW'(we_r[(k == 0) ? 2 : k - 1]) * PW'(ve_r[(k == 2) ? 0 : k + 1]);
        pa_r[k] <= PW'(ue_r[(k == 2) ? 0 : k + 1]) * PW'(we_r[(k == 0) ? 2 : k - 1]);
        pb_r[k] <= PW'(ue_r[(k == 0) ? 2 : k - 1]) * PW'(we_r[(k == 2) ? 0 : k + 1]);
        w2_r[k] <= we_r[k];
      end
    end
    if (go[2]) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k]  <= NW'(na_r[k]) - NW'(nb_r[k]);
        m_r[k]  <= NW'(ma_r[k]) - NW'(mb_r[k]);
        p_r[k]  <= NW'(pa_r[k]) - NW'(pb_r[k]);
        w3_r[k] <= w2_r[k];
      end
    end
    // dot products split into high and low partial products
    if (go[3]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          hp_r[j][k] <= HPW'($signed(xv[j][k][NW-1:LW])) * HPW'(yv[j][k]);
          lp_r[j][k] <= LPW'($signed({1'b0, xv[j][k][LW-1:0]})) * LPW'(yv[j][k]);
        end
      end
      nz4_r <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    end
    if (go[4]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          tm_r[j][k] <= (TW'(hp_r[j][k]) <<< LW) + TW'(lp_r[j][k]);
        end
      end
      nz5_r <= nz4_r;
    end
    if (go[5]) begin
      for (int j = 0; j < 4; j++) begin
        sm_r[j] <= SW'(tm_r[j][0]) + SW'(tm_r[j][1]) + SW'(tm_r[j][2]);
      end
      nz6_r <= nz5_r;
    end
    // fold the sign of the denominator into all numerators
    if (go[6]) begin
      den7_r  <= sm_r[0][SW-1] ? -sm_r[0] : sm_r[0];
      num7_r  <= sm_r[0][SW-1] ? sm_r[1] : -sm_r[1];
      sn7_r   <= sm_r[0][SW-1] ? -sm_r[2] : sm_r[2];
      tn7_r   <= sm_r[0][SW-1] ? -sm_r[3] : sm_r[3];
      dz7_r   <= (sm_r[0] == '0);
      numz7_r <= (sm_r[1] == '0);
      nz7_r   <= nz6_r;
    end
    if (go[7]) begin
      res_r.status <= st;
      res_r.den    <= den7_r;
      res_r.num    <= num7_r;
    end
  end

endmodule

// File: src/rti_scale.sv
// scaling stages: direction times numerator, magnitude and quotient range check
// depends on rti_pkg
module rti_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  rti_pkg::ray_t       ray,
  input  logic                in_valid,
  output logic                in_stall,
  input  rti_pkg::geom_res_t  in_res,
  output logic                out_valid,
  input  logic                out_stall,
  output rti_pkg::scale_res_t out_res
);

  localparam int NStg = 4;
  localparam int CW   = rti_pkg::CoordW;
  localparam int CHW  = rti_pkg::ChunkW;
  localparam int PPW  = rti_pkg::PartW;
  localparam int MGW  = rti_pkg::MagW;
  localparam int PRW  = MGW + 1;
  localparam int QW   = rti_pkg::QuoW;
  localparam int SW   = rti_pkg::SumW;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] go;

  logic signed [CW-1:0]  d [3];
  logic [3*CHW-1:0]      numx;
  logic signed [PPW-1:0] pp_r [3][3];
  logic signed [PRW-1:0] prod_r [3];
  logic [MGW-1:0]        mag_r [3];
  logic [2:0]            neg3_r;
  rti_pkg::status_t      stat_r [3];
  logic [SW-1:0]         den_r [3];
  rti_pkg::scale_res_t   res_r;

  assign d[0] = ray.dx;
  assign d[1] = ray.dy;
  assign d[2] = ray.dz;
  assign numx = (3*CHW)'(in_res.num);

  assign go[NStg-1] = !vld_r[NStg-1] || !out_stall;
  for (genvar i = 0; i < NStg - 1; i++) begin : g_go
    assign go[i] = !vld_r[i] || go[i+1];
  end

  assign in_stall  = !go[0];
  assign out_valid = vld_r[NStg-1];
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    // partial products on numerator chunks
    if (go[0]) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[k][j] <= PPW'(d[k]) * PPW'($signed({1'b0, numx[j*CHW +: CHW]}));
        end
      end
      stat_r[0] <= in_res.status;
      den_r[0]  <= in_res.den;
    end
    if (go[1]) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PRW'(pp_r[k][0]) + (PRW'(pp_r[k][1]) <<< CHW)
                     + (PRW'(pp_r[k][2]) <<< (2*CHW));
      end
      stat_r[1] <= stat_r[0];
      den_r[1]  <= den_r[0];
    end
    if (go[2]) begin
      for (int k = 0; k < 3; k++) begin
        neg3_r[k] <= prod_r[k][PRW-1];
        mag_r[k]  <= MGW'(prod_r[k][PRW-1] ? -prod_r[k] : prod_r[k]);
      end
      stat_r[2] <= stat_r[1];
      den_r[2]  <= den_r[1];
    end
    // quotient too wide for the divider means the point saturates anyway
    if (go[3]) begin
      for (int k = 0; k < 3; k++) begin
        res_r.ovf[k] <= SW'(mag_r[k][MGW-1:QW]) >= den_r[2];
        res_r.rem[k] <= SW'(mag_r[k][MGW-1:QW]);
        res_r.mlo[k] <= mag_r[k][QW-1:0];
      end
      res_r.neg    <= neg3_r;
      res_r.status <= stat_r[2];
      res_r.den    <= den_r[2];
    end
  end

endmodule

// File: src/rti_div.sv
// restoring divider, one quotient bit per stage, then rounding and saturation
// depends on rti_pkg
module rti_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rti_pkg::ray_t       ray,
  input  logic                in_valid,
  output logic                in_stall,
  input  rti_pkg::scale_res_t in_res,
  output logic                out_valid,
  input  logic                out_stall,
  output rti_pkg::hit_res_t   out_res
);

  localparam int CW   = rti_pkg::CoordW;
  localparam int QW   = rti_pkg::QuoW;
  localparam int SW   = rti_pkg::SumW;
  localparam int NStg = QW + 2;

  typedef struct packed {
    rti_pkg::status_t    status;
    logic [SW-1:0]       den;
    logic [2:0]          ovf;
    logic [2:0]          neg;
    logic [2:0][SW-1:0]  rem;
    logic [2:0][QW-1:0]  q;
    logic [2:0][QW-1:0]  mlo;
  } div_st_t;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] go;

  logic signed [CW-1:0] o [3];
  div_st_t              src [QW];
  div_st_t              nx [QW];
  div_st_t              dst_r [QW];
  logic [SW:0]          t;
  logic                 ge;

  rti_pkg::status_t     st1_r;
  logic [2:0]           ovf1_r, neg1_r;
  logic [QW:0]          qr1_r [3];
  logic signed [QW+1:0] vs [3];
  logic signed [QW+1:0] vn [3];
  logic signed [QW+2:0] sm [3];
  rti_pkg::coord_t      hv [3];
  rti_pkg::hit_res_t    res_r;

  assign o[0] = ray.ox;
  assign o[1] = ray.oy;
  assign o[2] = ray.oz;

  assign go[NStg-1] = !vld_r[NStg-1] || !out_stall;
  for (genvar i = 0; i < NStg - 1; i++) begin : g_go
    assign go[i] = !vld_r[i] || go[i+1];
  end

  assign in_stall  = !go[0];
  assign out_valid = vld_r[NStg-1];
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (go[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // each stage brings down one dividend bit, msb first
  always_comb begin
    src[0].status = in_res.status;
    src[0].den    = in_res.den;
    src[0].ovf    = in_res.ovf;
    src[0].neg    = in_res.neg;
    src[0].rem    = in_res.rem;
    src[0].q      = '0;
    src[0].mlo    = in_res.mlo;
    for (int i = 1; i < QW; i++) begin
      src[i] = dst_r[i-1];
    end
    t  = '0;
    ge = 1'b0;
    for (int i = 0; i < QW; i++) begin
      nx[i] = src[i];
      for (int k = 0; k < 3; k++) begin
        t  = {src[i].rem[k], src[i].mlo[k][QW-1-i]};
        ge = t >= {1'b0, src[i].den};
        nx[i].rem[k] = ge ? SW'(t - {1'b0, src[i].den}) : t[SW-1:0];
        nx[i].q[k]   = {src[i].q[k][QW-2:0], ge};
      end
    end
  end

  // signed offset, origin add and clamp to the coordinate range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vs[k] = $signed({1'b0, qr1_r[k]});
      vn[k] = neg1_r[k] ? -vs[k] : vs[k];
      sm[k] = (QW+3)'(o[k]) + (QW+3)'(vn[k]);
      if (st1_r != rti_pkg::STAT_HIT) begin
        hv[k] = '0;
      end else if (ovf1_r[k]) begin
        hv[k] = neg1_r[k] ? rti_pkg::CoordMin : rti_pkg::CoordMax;
      end else if ((&sm[k][QW+2:CW-1]) || !(|sm[k][QW+2:CW-1])) begin
        hv[k] = sm[k][CW-1:0];
      end else begin
        hv[k] = sm[k][QW+2] ? rti_pkg::CoordMin : rti_pkg::CoordMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      if (go[i]) dst_r[i] <= nx[i];
    end
    // round half away from zero on the magnitude
    if (go[QW]) begin
      for (int k = 0; k < 3; k++) begin
        qr1_r[k] <= (QW+1)'(dst_r[QW-1].q[k])
                    + (QW+1)'({dst_r[QW-1].rem[k], 1'b0} >= {1'b0, dst_r[QW-1].den});
      end
      st1_r  <= dst_r[QW-1].status;
      ovf1_r <= dst_r[QW-1].ovf;
      neg1_r <= dst_r[QW-1].neg;
    end
    if (go[QW+1]) begin
      res_r.status <= st1_r;
      res_r.x      <= hv[0];
      res_r.y      <= hv[1];
      res_r.z      <= hv[2];
    end
  end

endmodule

// File: src/ray_triangle_intersection_top.sv
// top level: configuration registers and the geometry, scale and divide pipeline
// depends on rti_pkg, rti_geom, rti_scale, rti_div
//
// usage
//   the ray origin and direction are written over the register port (byte
//   address 4*i: origin x, y, z, then direction x, y, z, signed q16.16) while
//   the pipeline is empty. each request on the in_ channel is one triangle;
//   each request on the out_ channel is one result: miss, hit with the
//   intersection point, or ray in the triangle's plane.
//   an accepted triangle passes 8 geometry stages, 4 scaling stages, 33
//   divider stages (one quotient bit each) and 2 rounding/clamp stages
//   before its result shows on out_valid. throughput is one triangle per
//   cycle while out_stall is low; the per-bit divider stages set the depth.
//   all stages hold valid bits; an empty stage always takes new data, so
//   bubbles close up while the receiver stalls and in_stall rises only when
//   every stage is full and out_stall is high.
//   reset clears every valid bit and sets the ray to origin 0, direction
//   (0, 0, 1.0); stalled results hold steady on the out_ ports.
module ray_triangle_intersection_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rti_pkg::AddrW-1:0]   paddr,
  input  logic [rti_pkg::DataW-1:0]   pwdata,
  output logic [rti_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // triangle requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_a_x,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_a_y,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_a_z,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_b_x,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_b_y,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_b_z,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_c_x,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_c_y,
  input  logic signed [rti_pkg::CoordW-1:0] in_vertex_c_z,
  // result requests
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_hit_status,
  output logic signed [rti_pkg::CoordW-1:0] out_hit_x,
  output logic signed [rti_pkg::CoordW-1:0] out_hit_y,
  output logic signed [rti_pkg::CoordW-1:0] out_hit_z
);

  rti_pkg::ray_t       ray_r, ray_nxt;
  rti_pkg::reg_idx_t   reg_idx;
  logic                cfg_wr;
  rti_pkg::tri_t       tri_in;
  rti_pkg::geom_res_t  geom_res;
  rti_pkg::scale_res_t scale_res;
  rti_pkg::hit_res_t   hit_res;
  logic                geom_valid, geom_stall;
  logic                scale_valid, scale_stall;

  // register port: no wait states, word addressed
  assign pready  = 1'b1;
  assign reg_idx = rti_pkg::reg_idx_t'(paddr[rti_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    ray_nxt = ray_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        rti_pkg::REG_ORG_X: ray_nxt.ox = pwdata;
        rti_pkg::REG_ORG_Y: ray_nxt.oy = pwdata;
        rti_pkg::REG_ORG_Z: ray_nxt.oz = pwdata;
        rti_pkg::REG_DIR_X: ray_nxt.dx = pwdata;
        rti_pkg::REG_DIR_Y: ray_nxt.dy = pwdata;
        rti_pkg::REG_DIR_Z: ray_nxt.dz = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rti_pkg::REG_ORG_X: prdata = ray_r.ox;
      rti_pkg::REG_ORG_Y: prdata = ray_r.oy;
      rti_pkg::REG_ORG_Z: prdata = ray_r.oz;
      rti_pkg::REG_DIR_X: prdata = ray_r.dx;
      rti_pkg::REG_DIR_Y: prdata = ray_r.dy;
      rti_pkg::REG_DIR_Z: prdata = ray_r.dz;
      default:            prdata = '0;
    endcase
  end

  // direction resets to unit z
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= rti_pkg::ray_t'{dz: rti_pkg::coord_t'(1) << rti_pkg::FracBits, default: '0};
    end else begin
      ray_r <= ray_nxt;
    end
  end

  assign tri_in.ax = in_vertex_a_x;
  assign tri_in.ay = in_vertex_a_y;
  assign tri_in.az = in_vertex_a_z;
  assign tri_in.bx = in_vertex_b_x;
  assign tri_in.by = in_vertex_b_y;
  assign tri_in.bz = in_vertex_b_z;
  assign tri_in.cx = in_vertex_c_x;
  assign tri_in.cy = in_vertex_c_y;
  assign tri_in.cz = in_vertex_c_z;

  // edges, normal, dot products, hit decision
  rti_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_tri    (tri_in),
    .out_valid (geom_valid),
    .out_stall (geom_stall),
    .out_res   (geom_res)
  );

  // direction times numerator, split for the divider
  rti_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .in_valid  (geom_valid),
    .in_stall  (geom_stall),
    .in_res    (geom_res),
    .out_valid (scale_valid),
    .out_stall (scale_stall),
    .out_res   (scale_res)
  );

  // quotient, rounding, origin add and clamp; last stage is the output register
  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .in_valid  (scale_valid),
    .in_stall  (scale_stall),
    .in_res    (scale_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (hit_res)
  );

  assign out_hit_status = hit_res.status;
  assign out_hit_x      = hit_res.x;
  assign out_hit_y      = hit_res.y;
  assign out_hit_z      = hit_res.z;

`ifndef SYNTHESIS
  // input is held back only when every stage is full behind a stalled result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // only a hit carries a point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_status != rti_pkg::STAT_HIT) |->
      (out_hit_x == '0 && out_hit_y == '0 && out_hit_z == '0))
    else $error("non-hit result with nonzero point");
`endif

endmodule
